// ----- hw/rtl/pba_pkg.sv -----
// pba_pkg: shared types and constants of the page bitmap allocator.
// Command, status and register codes, beat structs of both channels.
// No dependencies.
package pba_pkg;

	localparam int ADDR_W    = 48;
	localparam int LEN_W     = 32;
	localparam int PCNT_W    = 13;
	localparam int PSHIFT_W  = 5;
	localparam int CFG_IDX_W = 2;

	// commands
	localparam logic [1:0] CMD_ALLOC_ANY   = 2'd0;
	localparam logic [1:0] CMD_ALLOC_AT    = 2'd1;
	localparam logic [1:0] CMD_FREE        = 2'd2;
	localparam logic [1:0] CMD_ALLOC_RANGE = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd2;

	localparam logic [PCNT_W-1:0]   PAGE_COUNT_RST = 13'd4096;
	localparam logic [PSHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  length_bytes;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] result_address;
	} rsp_t;

	// word unit status flags
	typedef struct packed {
		logic all_ones;
		logic none;
	} wu_flags_t;

endpackage

// ----- hw/rtl/page_bitmap_allocator_top.sv -----
// page_bitmap_allocator_top: bitmap page frame allocator, top level.
// Uses pba_pkg, pba_bitmap_mem and pba_word_unit.
//
// Usage
//   Command beats: req is taken at a rising edge with start high and busy
//   low. busy stays high until the result is out. Result beats: done
//   is high for exactly one cycle with rsp valid; the receiver cannot stall
//   it, so it must take every result. busy drops in the cycle done is
//   high, so a new command may be issued right away.
//   Config: cfg_we writes cfg_data into register cfg_index (0 base_address,
//   1 page_count, 2 page_shift, others ignored); write only while idle.
// Sequence (from accept to done)
//   alloc at address / free: window check, constant divide, read, write.
//   alloc any: a read and an evaluate per bitmap word up to the first free page.
//   alloc range: page count, then a read and an evaluate per word scanned,
//   a bit walk of each word that is partly free (examined one bit per cycle),
//   and a read and a write per claimed word. The bitmap memory (one read or
//   one write a cycle) and the shared word unit set these steps.
// Reset
//   Registers take 0 / 4096 / 12. Every page starts used: after reset a
//   clearing pass writes zero to each bitmap word with busy high; config
//   writes are still taken.
module page_bitmap_allocator_top #(
	parameter int NUM_PAGES = 4096,
	parameter int WORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  pba_pkg::req_t                     req,
	output logic                              done,
	output pba_pkg::rsp_t                     rsp,
	input  logic                              cfg_we,
	input  logic [pba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pba_pkg::ADDR_W-1:0]        cfg_data
);
	import pba_pkg::*;

	localparam int WORD_COUNT = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int LIM_W      = BIT_W + 1;
	localparam int PAGE_W     = $clog2(NUM_PAGES + 1);
	localparam int BASE_W     = PAGE_W + 1;
	localparam int PROD_W     = 2 * PAGE_W;
	localparam int NEED_W     = LEN_W + 1;
	// reciprocal of WORD_BITS scaled by 2^PAGE_W; quotient is exact or one low
	localparam int RECIP      = (1 << PAGE_W) / WORD_BITS;

	typedef enum logic [15:0] {
		S_CLEAR   = 16'h0001,
		S_IDLE    = 16'h0002,
		S_NEED1   = 16'h0004,
		S_NEED2   = 16'h0008,
		S_SCAN_RD = 16'h0010,
		S_SCAN_EV = 16'h0020,
		S_BIT     = 16'h0040,
		S_MARK_RD = 16'h0080,
		S_MARK_WR = 16'h0100,
		S_WIN1    = 16'h0200,
		S_WIN2    = 16'h0400,
		S_DIV1    = 16'h0800,
		S_DIV2    = 16'h1000,
		S_RMW_RD  = 16'h2000,
		S_RMW_EV  = 16'h4000,
		S_ADDR    = 16'h8000
	} state_t;

	// control
	state_t              state_q, state_d;
	logic [WIDX_W-1:0]   clr_idx_q;
	logic                done_q;
	logic [ADDR_W-1:0]   base_q;
	logic [PCNT_W-1:0]   pcount_q;
	logic [PSHIFT_W-1:0] pshift_q;

	// working registers
	req_t                req_q;
	rsp_t                rsp_q;
	logic [PAGE_W-1:0]   pages_q;
	logic [WIDX_W-1:0]   word_idx_q;
	logic [BASE_W-1:0]   page_base_q;
	logic [PAGE_W-1:0]   run_q;
	logic [PAGE_W-1:0]   need_q;
	logic [PAGE_W-1:0]   remain_q;
	logic [BIT_W-1:0]    bit_q;
	logic [WORD_BITS-1:0] word_q;
	logic [PAGE_W-1:0]   n_q;
	logic                in_low_q;
	logic [ADDR_W-1:0]   off_q;
	logic [NEED_W-1:0]   sum_q;
	logic [PROD_W-1:0]   prod_q;

	// memory and word unit
	logic                mem_we, mem_re;
	logic [WIDX_W-1:0]   mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
	logic [LIM_W-1:0]    wu_limit;
	logic [BIT_W-1:0]    wu_lo, wu_hi, wu_first;
	logic                wu_set;
	logic [WORD_BITS-1:0] wu_masked, wu_updated;
	wu_flags_t           wu_flags;

	// helpers
	logic [PAGE_W-1:0]   pages_d;
	logic                clr_last;
	logic [NEED_W-1:0]   need_full;
	logic                need_bad;
	logic [ADDR_W-1:0]   off_sh;
	logic                win_out;
	logic [PAGE_W-1:0]   q0, div_q;
	logic [31:0]         qw, rem0, div_r;
	logic                div_fix;
	logic                scan_has;
	logic [BASE_W-1:0]   avail;
	logic [BASE_W-1:0]   run_w;
	logic                full_hit;
	logic [PAGE_W-1:0]   gap;
	logic                bit_free, bit_hit, bit_last;
	logic [PAGE_W-1:0]   bit_run;
	logic [BIT_W-1:0]    end_bit;
	logic [BASE_W-1:0]   start_pg, any_pg;
	logic                scan_adv;
	logic [BASE_W-1:0]   span, taken, remain_w;
	logic [BIT_W-1:0]    mark_lo;
	logic [63:0]         pa_full;
	logic                is_any, is_free;
	logic                fin;
	logic [1:0]          fin_status;
	logic [ADDR_W-1:0]   fin_addr;

	pba_bitmap_mem #(
		.DEPTH(WORD_COUNT),
		.WIDTH(WORD_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(word_idx_q),
		.rdata(mem_rdata)
	);

	pba_word_unit #(
		.WORD_BITS(WORD_BITS)
	) u_word (
		.word    (mem_rdata),
		.limit   (wu_limit),
		.lo      (wu_lo),
		.hi      (wu_hi),
		.set_bits(wu_set),
		.masked  (wu_masked),
		.updated (wu_updated),
		.first   (wu_first),
		.flags   (wu_flags)
	);

	// page_count beyond the array size acts as the array size
	always_comb begin
		if (32'(pcount_q) > 32'(NUM_PAGES)) pages_d = PAGE_W'(NUM_PAGES);
		else pages_d = PAGE_W'(pcount_q);
	end

	assign is_any  = (req_q.cmd == CMD_ALLOC_ANY);
	assign is_free = (req_q.cmd == CMD_FREE);
	assign clr_last = (clr_idx_q == WIDX_W'(WORD_COUNT - 1));

	// range length in pages
	assign need_full = sum_q >> pshift_q;
	assign need_bad  = (need_full == '0) || (need_full > NEED_W'(pages_q));

	// window check
	assign off_sh  = off_q >> pshift_q;
	assign win_out = !in_low_q || (off_sh >= ADDR_W'(pages_q));

	// page index to word/bit by reciprocal multiply and one correction
	always_comb begin
		q0      = prod_q[PROD_W-1:PAGE_W];
		qw      = 32'(q0) * 32'(WORD_BITS);
		rem0    = 32'(n_q) - qw;
		div_fix = (rem0 >= 32'(WORD_BITS));
		div_q   = div_fix ? q0 + 1'b1 : q0;
		div_r   = div_fix ? rem0 - 32'(WORD_BITS) : rem0;
	end

	// scan helpers
	always_comb begin
		scan_has = (page_base_q < BASE_W'(pages_q));
		avail    = BASE_W'(pages_q) - page_base_q;
		if (avail >= BASE_W'(WORD_BITS)) wu_limit = LIM_W'(WORD_BITS);
		else wu_limit = avail[LIM_W-1:0];
		run_w    = BASE_W'(run_q) + BASE_W'(WORD_BITS);
		full_hit = wu_flags.all_ones && (run_w >= BASE_W'(need_q));
		gap      = need_q - run_q - 1'b1;
		bit_free = word_q[bit_q];
		bit_run  = bit_free ? run_q + 1'b1 : '0;
		bit_hit  = (bit_run == need_q);
		bit_last = (bit_q == BIT_W'(WORD_BITS - 1));
		end_bit  = (state_q == S_BIT) ? bit_q : gap[BIT_W-1:0];
		start_pg = page_base_q + BASE_W'(end_bit) + BASE_W'(1) - BASE_W'(need_q);
		any_pg   = page_base_q + BASE_W'(wu_first);
		if (is_any) scan_adv = wu_flags.none;
		else scan_adv = wu_flags.none || (wu_flags.all_ones && !full_hit);
	end

	// claiming a run goes backwards from its last page, one word at a time
	always_comb begin
		span = BASE_W'(bit_q) + BASE_W'(1);
		if (span >= BASE_W'(remain_q)) begin
			taken = BASE_W'(remain_q);
		end else begin
			taken = span;
		end
		remain_w = BASE_W'(remain_q) - taken;
		mark_lo  = BIT_W'(span - taken);
	end

	assign pa_full = 64'(base_q) + (64'(n_q) << pshift_q);

	// word unit and memory control
	always_comb begin
		wu_lo     = bit_q;
		wu_hi     = bit_q;
		wu_set    = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = word_idx_q;
		mem_wdata = wu_updated;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '0;
			end
			S_SCAN_RD: begin
				mem_re = scan_has;
			end
			S_SCAN_EV: begin
				wu_lo  = wu_first;
				wu_hi  = wu_first;
				mem_we = is_any && !wu_flags.none;
			end
			S_MARK_RD, S_RMW_RD: begin
				mem_re = 1'b1;
			end
			S_MARK_WR: begin
				wu_lo  = mark_lo;
				mem_we = 1'b1;
			end
			S_RMW_EV: begin
				wu_set = is_free;
				mem_we = is_free || mem_rdata[bit_q];
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_addr   = '0;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					case (req.cmd)
						CMD_ALLOC_ANY: state_d = S_SCAN_RD;
						CMD_ALLOC_RANGE: state_d = S_NEED1;
						default: state_d = S_WIN1;
					endcase
				end
			end
			S_NEED1: state_d = S_NEED2;
			S_NEED2: begin
				if (need_bad) begin
					fin        = 1'b1;
					fin_status = ST_NOSPACE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (!scan_has) begin
					fin        = 1'b1;
					fin_status = ST_NOSPACE;
				end else begin
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				if (scan_adv) state_d = S_SCAN_RD;
				else if (is_any) state_d = S_ADDR;
				else if (full_hit) state_d = S_MARK_RD;
				else state_d = S_BIT;
			end
			S_BIT: begin
				if (bit_hit) state_d = S_MARK_RD;
				else if (bit_last) state_d = S_SCAN_RD;
			end
			S_MARK_RD: state_d = S_MARK_WR;
			S_MARK_WR: begin
				if (remain_w == '0) state_d = S_ADDR;
				else state_d = S_MARK_RD;
			end
			S_WIN1: state_d = S_WIN2;
			S_WIN2: begin
				if (win_out) begin
					fin        = 1'b1;
					fin_status = ST_RANGE;
				end else begin
					state_d = S_DIV1;
				end
			end
			S_DIV1: state_d = S_DIV2;
			S_DIV2: state_d = S_RMW_RD;
			S_RMW_RD: state_d = S_RMW_EV;
			S_RMW_EV: begin
				fin = 1'b1;
				if (is_free) begin
					fin_status = ST_OK;
				end else if (mem_rdata[bit_q]) begin
					fin_status = ST_OK;
					fin_addr   = req_q.address;
				end else begin
					fin_status = ST_NOSPACE;
				end
			end
			S_ADDR: begin
				fin      = 1'b1;
				fin_addr = pa_full[ADDR_W-1:0];
			end
			default: state_d = S_IDLE;
		endcase
		if (fin) state_d = S_IDLE;
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_idx_q <= '0;
			done_q    <= 1'b0;
			base_q    <= '0;
			pcount_q  <= PAGE_COUNT_RST;
			pshift_q  <= PAGE_SHIFT_RST;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE_ADDRESS: base_q <= cfg_data;
					CFG_PAGE_COUNT: pcount_q <= cfg_data[PCNT_W-1:0];
					CFG_PAGE_SHIFT: pshift_q <= cfg_data[PSHIFT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q.status         <= fin_status;
			rsp_q.result_address <= fin_addr;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q       <= req;
					pages_q     <= pages_d;
					word_idx_q  <= '0;
					page_base_q <= '0;
					run_q       <= '0;
				end
			end
			S_NEED1: begin
				sum_q <= NEED_W'(req_q.length_bytes) + (NEED_W'(1) << pshift_q) - NEED_W'(1);
			end
			S_NEED2: need_q <= need_full[PAGE_W-1:0];
			S_SCAN_EV: begin
				word_q <= wu_masked;
				if (is_any) begin
					bit_q <= '0;
					n_q   <= any_pg[PAGE_W-1:0];
				end else if (full_hit) begin
					bit_q    <= end_bit;
					remain_q <= need_q;
					n_q      <= start_pg[PAGE_W-1:0];
				end else begin
					bit_q <= '0;
					if (wu_flags.all_ones) begin
						run_q <= run_w[PAGE_W-1:0];
					end else if (wu_flags.none) begin
						run_q <= '0;
					end
				end
				if (scan_adv) begin
					word_idx_q  <= word_idx_q + 1'b1;
					page_base_q <= page_base_q + BASE_W'(WORD_BITS);
				end
			end
			S_BIT: begin
				run_q <= bit_run;
				if (bit_hit) begin
					remain_q <= need_q;
					n_q      <= start_pg[PAGE_W-1:0];
				end else if (bit_last) begin
					word_idx_q  <= word_idx_q + 1'b1;
					page_base_q <= page_base_q + BASE_W'(WORD_BITS);
				end else begin
					bit_q <= bit_q + 1'b1;
				end
			end
			S_MARK_WR: begin
				remain_q   <= remain_w[PAGE_W-1:0];
				word_idx_q <= word_idx_q - 1'b1;
				bit_q      <= BIT_W'(WORD_BITS - 1);
			end
			S_WIN1: begin
				in_low_q <= (req_q.address >= base_q);
				off_q    <= req_q.address - base_q;
			end
			S_WIN2: n_q <= off_sh[PAGE_W-1:0];
			S_DIV1: prod_q <= PROD_W'(n_q) * PROD_W'(RECIP);
			S_DIV2: begin
				word_idx_q <= div_q[WIDX_W-1:0];
				bit_q      <= div_r[BIT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- hw/rtl/pba_bitmap_mem.sv -----
// pba_bitmap_mem: bitmap word store, one write and one read port.
// Read data registered. No dependencies.
module pba_bitmap_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/pba_word_unit.sv -----
// pba_word_unit: shared per-word logic: valid masking, lowest free bit,
// full/empty flags and bit-range set/clear. Depends on pba_pkg.
module pba_word_unit #(
	parameter int WORD_BITS = 32
) (
	input  logic [WORD_BITS-1:0]         word,
	input  logic [$clog2(WORD_BITS):0]   limit,
	input  logic [$clog2(WORD_BITS)-1:0] lo,
	input  logic [$clog2(WORD_BITS)-1:0] hi,
	input  logic                         set_bits,
	output logic [WORD_BITS-1:0]         masked,
	output logic [WORD_BITS-1:0]         updated,
	output logic [$clog2(WORD_BITS)-1:0] first,
	output pba_pkg::wu_flags_t           flags
);
	import pba_pkg::*;

	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int LIM_W = BIT_W + 1;

	logic [WORD_BITS-1:0] sel;

	// bits at or above limit lie past the window: treated as used
	always_comb begin
		masked = '0;
		sel    = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (LIM_W'(i) < limit) masked[i] = word[i];
			if (BIT_W'(i) >= lo && BIT_W'(i) <= hi) sel[i] = 1'b1;
		end
	end

	// lowest set bit
	always_comb begin
		first = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (masked[i]) first = BIT_W'(i);
		end
	end

	assign updated        = set_bits ? (word | sel) : (word & ~sel);
	assign flags.all_ones = &masked;
	assign flags.none     = ~|masked;

endmodule

// ----- hw/rtl/pba_checker.sv -----
// pba_checker: port-level checks of the page bitmap allocator, bound to
// the top level. Depends on pba_pkg and page_bitmap_allocator_top.
module pba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input pba_pkg::rsp_t rsp
);
	import pba_pkg::*;

	// an accepted command raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// a result beat ends the command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	// never two result beats back to back
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_RANGE ||
			rsp.status == ST_NOSPACE))
		else $error("undefined status code");

	// failures carry a zero address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.result_address == '0)
		else $error("failed command returned an address");

endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
